### sv/bool_dec_pkg.sv
// Shared types and constants for the boolean arithmetic decoder.
`timescale 1ns / 1ps

package bool_dec_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] PRIME_BYTES = 3'd4;
   localparam logic [7:0] RANGE_INIT  = 8'd255;
   localparam logic [3:0] SHIFT_INIT  = 4'd8;

   typedef logic [QPTR_W-1:0] qptr_type;
   typedef logic [QLVL_W-1:0] qlvl_type;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_DECODE  = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DROPPED   = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_UNPRIMED  = 2'd3
   } status_type;

endpackage

### sv/boolean_arithmetic_decoder_core.sv
// Boolean arithmetic decoder: input register, combinational decode and result register.
`timescale 1ns / 1ps

// Takes one item per clock when not stalled (load byte, decode one bool, restart)
// and returns exactly one result item for each via the input and result registers.
// The rate of one item per cycle is set by the single decode path between the input
// register and the result register: an 8x8 multiply for the split, a compare
// against the top byte of the code value, a leading-zero renormalizing shift and the
// merge of at most one queued byte. Bytes loaded after the four priming bytes wait in
// a QUEUE_DEPTH-entry byte queue held in flops; its contents need no clearing.
module boolean_arithmetic_decoder_core
   import bool_dec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] byte_in, [15:8] probability
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] bit_out, [2:1] status, [7:3] zero
);

   // input register
   logic       in_valid_ff, in_valid_in;
   op_type     in_op_ff;
   logic [7:0] in_byte_ff;
   logic [7:0] in_prob_ff;

   // decoder state
   logic [31:0] code_value_ff, code_value_in;
   logic [7:0]  code_range_ff, code_range_in;
   logic [3:0]  shift_count_ff, shift_count_in;
   logic [2:0]  prime_count_ff, prime_count_in;
   qlvl_type    queue_level_ff, queue_level_in;
   qptr_type    queue_head_ff, queue_head_in;
   qptr_type    queue_tail_ff, queue_tail_in;
   logic [7:0]  byte_queue_ff [QUEUE_DEPTH];
   logic        q_wr_en;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_bit_ff, rsp_bit_in;
   status_type rsp_status_ff, rsp_status_in;

   logic req_accept;
   logic advance;
   logic fire;

   // decode path
   logic [7:0]        range_m1;
   logic [15:0]       product;
   logic [7:0]        split;
   logic              dec_bit;
   logic [7:0]        range_a;
   logic [31:0]       value_a;
   logic [2:0]        norm_shift;
   logic [7:0]        range_s;
   logic [31:0]       value_s;
   logic signed [4:0] count;
   logic [4:0]        count_adj;
   logic              need_byte;
   logic              queue_empty;
   logic              queue_full;
   logic [7:0]        fetched;
   logic [2:0]        merge_shift;
   logic [31:0]       value_d;
   logic [3:0]        shift_count_d;
   qptr_type          head_next;
   qptr_type          tail_next;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_status_ff, rsp_bit_ff};

   assign queue_empty = (queue_level_ff == '0);
   assign queue_full  = (queue_level_ff == QLVL_W'(QUEUE_DEPTH));
   assign head_next   = (queue_head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : queue_head_ff + 1'b1;
   assign tail_next   = (queue_tail_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : queue_tail_ff + 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff   <= op_type'(req_tuser);
         in_byte_ff <= req_tdata[7:0];
         in_prob_ff <= req_tdata[15:8];
      end
   end

   // split, compare and renormalize
   always_comb begin
      range_m1 = code_range_ff - 8'd1;
      product  = 16'(range_m1) * 16'(in_prob_ff);
      split    = (code_range_ff == 8'd0) ? 8'd1 : 8'd1 + product[15:8];
      // value >= split << 24 reduces to a compare on the top byte
      dec_bit  = (code_value_ff[31:24] >= split);
      if (dec_bit) begin
         range_a = code_range_ff - split;
         value_a = {code_value_ff[31:24] - split, code_value_ff[23:0]};
      end else begin
         range_a = split;
         value_a = code_value_ff;
      end

      if (range_a[7]) begin
         norm_shift = 3'd0;
      end else if (range_a[6]) begin
         norm_shift = 3'd1;
      end else if (range_a[5]) begin
         norm_shift = 3'd2;
      end else if (range_a[4]) begin
         norm_shift = 3'd3;
      end else if (range_a[3]) begin
         norm_shift = 3'd4;
      end else if (range_a[2]) begin
         norm_shift = 3'd5;
      end else if (range_a[1]) begin
         norm_shift = 3'd6;
      end else begin
         norm_shift = 3'd7;   // range of one or zero; shift capped
      end

      range_s = range_a << norm_shift;
      value_s = value_a << norm_shift;

      count     = $signed({1'b0, shift_count_ff}) - $signed({2'b0, norm_shift});
      need_byte = (norm_shift != 3'd0) && (count[4] || (count == 5'sd0));
      count_adj = 5'(count + 5'sd8);   // 1..8 whenever a byte is needed

      fetched     = queue_empty ? 8'd0 : byte_queue_ff[queue_head_ff];
      merge_shift = 3'(4'd8 - count_adj[3:0]);
      value_d     = value_s;
      if (need_byte) begin
         value_d = value_s | (32'(fetched) << merge_shift);
      end

      shift_count_d = shift_count_ff;
      if (norm_shift != 3'd0) begin
         shift_count_d = need_byte ? count_adj[3:0] : count[3:0];
      end
   end

   // state and result update for the item leaving the input register
   always_comb begin
      code_value_in  = code_value_ff;
      code_range_in  = code_range_ff;
      shift_count_in = shift_count_ff;
      prime_count_in = prime_count_ff;
      queue_level_in = queue_level_ff;
      queue_head_in  = queue_head_ff;
      queue_tail_in  = queue_tail_ff;
      q_wr_en        = 1'b0;
      rsp_bit_in     = 1'b0;
      rsp_status_in  = ST_OK;

      if (fire) begin
         case (in_op_ff)
            OP_LOAD: begin
               if (prime_count_ff < PRIME_BYTES) begin
                  code_value_in  = {code_value_ff[23:0], in_byte_ff};
                  prime_count_in = prime_count_ff + 3'd1;
               end else if (queue_full) begin
                  rsp_status_in = ST_DROPPED;
               end else begin
                  q_wr_en        = 1'b1;
                  queue_tail_in  = tail_next;
                  queue_level_in = queue_level_ff + 1'b1;
               end
            end
            OP_DECODE: begin
               if (prime_count_ff < PRIME_BYTES) begin
                  rsp_status_in = ST_UNPRIMED;
               end else begin
                  rsp_bit_in     = dec_bit;
                  code_value_in  = value_d;
                  code_range_in  = range_s;
                  shift_count_in = shift_count_d;
                  if (need_byte) begin
                     if (queue_empty) begin
                        rsp_status_in = ST_UNDERFLOW;
                     end else begin
                        queue_head_in  = head_next;
                        queue_level_in = queue_level_ff - 1'b1;
                     end
                  end
               end
            end
            OP_RESTART: begin
               code_value_in  = '0;
               code_range_in  = RANGE_INIT;
               shift_count_in = SHIFT_INIT;
               prime_count_in = '0;
               queue_level_in = '0;
               queue_head_in  = '0;
               queue_tail_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_value_ff  <= '0;
         code_range_ff  <= RANGE_INIT;
         shift_count_ff <= SHIFT_INIT;
         prime_count_ff <= '0;
         queue_level_ff <= '0;
         queue_head_ff  <= '0;
         queue_tail_ff  <= '0;
      end else begin
         code_value_ff  <= code_value_in;
         code_range_ff  <= code_range_in;
         shift_count_ff <= shift_count_in;
         prime_count_ff <= prime_count_in;
         queue_level_ff <= queue_level_in;
         queue_head_ff  <= queue_head_in;
         queue_tail_ff  <= queue_tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         byte_queue_ff[queue_tail_ff] <= in_byte_ff;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_bit_ff    <= rsp_bit_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

endmodule

### sv/bool_dec_checker.sv
// Port-level checks for the boolean arithmetic decoder, bound to the top level.
`timescale 1ns / 1ps

module bool_dec_checker
   import bool_dec_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // input side only stalls behind a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

   // dropped or unprimed items carry no decoded bit
   a_no_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:1] == ST_DROPPED || rsp_tdata[2:1] == ST_UNPRIMED)
      |-> !rsp_tdata[0])
      else $error("decoded bit set on a non-decode status");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result item right after reset");

endmodule

bind boolean_arithmetic_decoder_core bool_dec_checker u_bool_dec_checker (.*);

### tb/tb_top.sv
// Self-checking bench for the boolean arithmetic decoder core: stream driver, scoreboard, watchdog.
`timescale 1ns / 1ps

module tb_top;
   import bool_dec_pkg::*;

   localparam logic [1:0] OP_RESERVED    = 2'd3;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         TARGET_ITEMS   = 1000;
   localparam int         DRAIN_CYCLES   = 12;
   localparam int         MAX_PRINTED    = 40;

   typedef struct {
      logic       bit_out;
      status_type status;
   } bool_result_type;

   // Scoreboard: tracks the decoder state and holds the expected result of each item
   class bool_decode_scoreboard;
      logic [31:0] code_value;
      logic [7:0]  code_range;
      logic [3:0]  shift_count;
      logic [2:0]  prime_count;
      logic [7:0]  byte_queue [QUEUE_DEPTH];
      qlvl_type    queue_level;
      qptr_type    queue_head;
      qptr_type    queue_tail;
      bool_result_type expected_q[$];
      int errors;
      int op_count [4];
      int status_count [4];
      int ones_count;
      int zeros_count;

      function new();
         errors = 0;
         ones_count = 0;
         zeros_count = 0;
         foreach (op_count[i]) op_count[i] = 0;
         foreach (status_count[i]) status_count[i] = 0;
         restart();
      endfunction

      function void restart();
         code_value  = '0;
         code_range  = RANGE_INIT;
         shift_count = SHIFT_INIT;
         prime_count = '0;
         queue_level = '0;
         queue_head  = '0;
         queue_tail  = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function status_type push_byte(logic [7:0] byte_in);
         if (prime_count < PRIME_BYTES) begin
            code_value  = {code_value[23:0], byte_in};
            prime_count = prime_count + 3'd1;
            return ST_OK;
         end
         if (queue_level >= QUEUE_DEPTH)
            return ST_DROPPED;
         byte_queue[queue_tail] = byte_in;
         queue_tail  = queue_tail + 1'b1;
         queue_level = queue_level + 1'b1;
         return ST_OK;
      endfunction

      // false (and a zero byte) when nothing is queued
      function bit pop_byte(output logic [7:0] fill);
         if (queue_level == 0) begin
            fill = 8'd0;
            return 1'b0;
         end
         fill = byte_queue[queue_head];
         queue_head  = queue_head + 1'b1;
         queue_level = queue_level - 1'b1;
         return 1'b1;
      endfunction

      function void decode_bool(logic [7:0] prob, output logic bit_out,
                                output status_type status);
         logic [7:0]  rng;
         logic [7:0]  rng_less;
         logic [31:0] val;
         logic [15:0] prod;
         logic [7:0]  split;
         logic [31:0] split_top;
         logic [7:0]  fill;
         int          sh;
         int          cnt;
         status   = ST_OK;
         rng      = code_range;
         val      = code_value;
         rng_less = rng - 8'd1;
         prod     = rng_less * prob;
         split    = 8'd1 + prod[15:8];
         if (rng == 8'd0)
            split = 8'd1;
         split_top = {split, 24'd0};
         if (val >= split_top) begin
            rng     = rng - split;
            val     = val - split_top;
            bit_out = 1'b1;
         end else begin
            rng     = split;
            bit_out = 1'b0;
         end
         // leading-zero renormalize, shift capped at 7
         sh = 0;
         while (sh < 7 && rng[7-sh] == 1'b0)
            sh++;
         if (sh > 0) begin
            val = val << sh;
            rng = rng << sh;
            cnt = int'(shift_count) - sh;
            if (cnt <= 0) begin
               cnt += 8;
               if (!pop_byte(fill))
                  status = ST_UNDERFLOW;
               if (cnt >= 1 && cnt <= 8)
                  val = val | ({24'd0, fill} << (8 - cnt));
            end
            shift_count = cnt[3:0];
         end
         code_value = val;
         code_range = rng;
      endfunction

      function void note_input(logic [1:0] op, logic [7:0] byte_in, logic [7:0] prob);
         bool_result_type r;
         r.bit_out = 1'b0;
         r.status  = ST_OK;
         op_count[op]++;
         case (op)
            OP_LOAD: begin
               r.status = push_byte(byte_in);
            end
            OP_DECODE: begin
               if (prime_count < PRIME_BYTES)
                  r.status = ST_UNPRIMED;
               else
                  decode_bool(prob, r.bit_out, r.status);
            end
            OP_RESTART: begin
               restart();
            end
            default: ;
         endcase
         expected_q.push_back(r);
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, msg);
      endtask

      task check_result(logic bit_out, logic [1:0] status);
         bool_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result item with none expected (bit %0d status %0d)",
                                      bit_out, status));
            return;
         end
         want = expected_q.pop_front();
         status_count[want.status]++;
         if (want.bit_out) ones_count++; else zeros_count++;
         if (bit_out !== want.bit_out)
            report_mismatch($sformatf("bit_out %0b, expected %0b", bit_out, want.bit_out));
         if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %s", status, want.status.name()));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;     // [7:0] byte_in, [15:8] probability
   logic [1:0]  req_tuser = '0;     // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [0] bit_out, [2:1] status, [7:3] zero

   bool_decode_scoreboard sb = new();
   int  items_sent   = 0;
   int  idle_cycles  = 0;
   bit  steady_sender = 1'b0;

   boolean_arithmetic_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic logic [7:0] pick_prob();
      int r;
      r = $urandom_range(0, 19);
      case (r)
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd128;
         3: return 8'd1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Drives one item and returns at the edge where it is accepted.
   task automatic send_item(logic [1:0] op, logic [7:0] byte_in, logic [7:0] prob);
      int gap;
      gap = steady_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {prob, byte_in};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_load(logic [7:0] byte_in);
      send_item(OP_LOAD, byte_in, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_decode(logic [7:0] prob);
      send_item(OP_DECODE, 8'($urandom_range(0, 255)), prob);
   endtask

   task automatic send_restart();
      send_item(OP_RESTART, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   task automatic prime_decoder();
      send_restart();
      repeat (4) send_load(8'($urandom_range(0, 255)));
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() > 0);
   endtask

   // result side: ready stretches broken by stalls of random length
   initial begin
      int run_len;
      int stall;
      forever begin
         run_len = $urandom_range(1, 40);
         rsp_tready <= 1'b1;
         repeat (run_len) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_input(req_tuser, req_tdata[7:0], req_tdata[15:8]);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[0], rsp_tdata[2:1]);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int seq_kind;
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unprimed decode, unused op, priming, queue overflow, edge probabilities
      send_decode(8'd128);
      send_item(OP_RESERVED, 8'hFF, 8'hFF);
      send_load(8'hFF);
      send_load(8'h00);
      send_load(8'h80);
      send_load(8'h7F);
      for (int i = 0; i < 17; i++)
         send_load(8'(i * 15));
      send_decode(8'd0);
      send_decode(8'd128);
      send_decode(8'd255);
      send_decode(8'd1);
      hold_until_drained();

      // random: mostly primed streams, some bursts, starvation and noise
      while (items_sent < TARGET_ITEMS) begin
         steady_sender = ($urandom_range(0, 3) == 0);
         seq_kind = $urandom_range(0, 9);
         if (seq_kind <= 5) begin
            prime_decoder();
            n = $urandom_range(5, 40);
            repeat (n) begin
               if ($urandom_range(0, 9) < 6)
                  send_decode(pick_prob());
               else
                  send_load(8'($urandom_range(0, 255)));
            end
         end else if (seq_kind == 6) begin
            // fill the byte queue, at times past full, then decode it down
            prime_decoder();
            repeat ($urandom_range(16, 20)) send_load(8'($urandom_range(0, 255)));
            repeat ($urandom_range(10, 40)) send_decode(pick_prob());
         end else if (seq_kind == 7) begin
            // decode far past the queued bytes to hit underflow
            prime_decoder();
            repeat ($urandom_range(0, 2)) send_load(8'($urandom_range(0, 255)));
            repeat ($urandom_range(10, 30)) send_decode(pick_prob());
         end else if (seq_kind == 8) begin
            repeat ($urandom_range(5, 15))
               send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
         end else begin
            // broken priming: restart partway through
            send_restart();
            repeat ($urandom_range(0, 3)) send_load(8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 4)) send_decode(pick_prob());
            hold_until_drained();
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d loads, %0d decodes, %0d restarts, %0d unused-op",
               items_sent, sb.op_count[OP_LOAD], sb.op_count[OP_DECODE],
               sb.op_count[OP_RESTART], sb.op_count[OP_RESERVED]);
      $display("Results: ok %0d, dropped %0d, underflow %0d, unprimed %0d; bits 0/1: %0d/%0d",
               sb.status_count[ST_OK], sb.status_count[ST_DROPPED],
               sb.status_count[ST_UNDERFLOW], sb.status_count[ST_UNPRIMED],
               sb.zeros_count, sb.ones_count);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
